[src/edc_pkg.sv]
// shared types, constants and face lookup for the electronic dice controller
// no dependencies
package edc_pkg;

  localparam int SleepWidth = 16;
  localparam int FlipWidth  = 8;
  localparam int WordWidth  = 16;
  localparam int FaceWidth  = 3;
  localparam int LedWidth   = 4;
  localparam int CfgWidth   = 16;

  localparam logic [SleepWidth-1:0] SLEEP_RESET  = 16'd20000;
  localparam logic [FlipWidth-1:0]  FLIP_RESET   = 8'd80;
  localparam logic [WordWidth-1:0]  SEED         = 16'd1;
  localparam logic [WordWidth-1:0]  REJECT_ABOVE = 16'hFFFB;

  // floor(w / 6) == (w * DIV6_MUL) >> DIV6_SHIFT for any 16-bit w
  localparam logic [15:0] DIV6_MUL   = 16'd43691;
  localparam int          DIV6_SHIFT = 18;

  typedef enum logic [0:0] {
    REG_SLEEP_TICKS = 1'b0,
    REG_FLIP_TICKS  = 1'b1
  } cfg_reg_t;

  function automatic logic [LedWidth-1:0] face_leds(input logic [FaceWidth-1:0] face);
    logic [LedWidth-1:0] leds;
    case (face)
      3'd0: leds = 4'b0001;
      3'd1: leds = 4'b0010;
      3'd2: leds = 4'b0011;
      3'd3: leds = 4'b0110;
      3'd4: leds = 4'b0111;
      3'd5: leds = 4'b1110;
      default: leds = 4'b0001;
    endcase
    return leds;
  endfunction

endpackage

[src/edc_draw.sv]
// one die draw: xorshift generator with a shared shift stage, rejection and mod 6
// depends on edc_pkg
module edc_draw (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          done,
  output logic [edc_pkg::FaceWidth-1:0] face
);
  import edc_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE,
    D_SHIFT,
    D_CHECK,
    D_MUL,
    D_MOD
  } draw_state_t;

  draw_state_t state;
  logic [WordWidth-1:0] word;
  logic [1:0] step;
  logic [31:0] product;

  logic [WordWidth-1:0] shifted;
  logic [13:0] quot;
  logic [WordWidth-1:0] remainder;

  // shared shift unit, one xorshift term per cycle
  always_comb begin
    case (step)
      2'd0: shifted = word << 9;
      2'd1: shifted = word >> 7;
      2'd2: shifted = word << 13;
      default: shifted = '0;
    endcase
  end

  assign quot      = product[31:DIV6_SHIFT];
  assign remainder = word - ({2'b00, quot} << 2) - ({2'b00, quot} << 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      word  <= SEED;
      step  <= '0;
      done  <= 1'b0;
    end else begin
      case (state)
        D_IDLE: begin
          done <= 1'b0;
          if (start) begin
            step  <= '0;
            state <= D_SHIFT;
          end
        end
        D_SHIFT: begin
          word <= word ^ shifted;
          if (step == 2'd2) begin
            state <= D_CHECK;
          end
          step <= step + 2'd1;
        end
        D_CHECK: begin
          step <= '0;
          if (word > REJECT_ABOVE) begin
            state <= D_SHIFT;
          end else begin
            state <= D_MUL;
          end
        end
        D_MUL: begin
          product <= 32'(word) * 32'(DIV6_MUL);
          state   <= D_MOD;
        end
        D_MOD: begin
          face  <= remainder[FaceWidth-1:0];
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

[src/electronic_dice_controller.sv]
// two-die dice controller advanced one tick per input request
// depends on edc_pkg and edc_draw
//
// usage: each input request carries the button level of one tick and yields
// exactly one output request with both faces, their led group patterns and
// the shuffling and asleep flags after the tick's update.
// configuration: cfg_write with cfg_index 0 sets sleep_ticks, 1 sets
// flip_ticks; write only while the block is idle.
// order: a tick without a redraw passes from the idle state to S_DONE, which
// raises out_valid once the output register is free. a tick that redraws runs
// the draw unit twice; one draw goes from launch through start, three shift
// steps, reject check, multiply, remainder and done, and every rejected word
// repeats the three shift steps and the reject check.
// throughput: one request at a time; in_ready is high only between ticks, in
// the idle state, so a request waits until the previous result is registered.
// the output register holds a result until taken, and the next request is
// accepted meanwhile; a stalled receiver holds the following result back.
// reset: config returns to 20000 and 80, mode idle, generator seeded with 1,
// dice lit on face one, no output pending.
module electronic_dice_controller #(
  parameter logic [edc_pkg::SleepWidth-1:0] SLEEP_DEFAULT = edc_pkg::SLEEP_RESET,
  parameter logic [edc_pkg::FlipWidth-1:0]  FLIP_DEFAULT  = edc_pkg::FLIP_RESET
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [edc_pkg::CfgWidth-1:0]  cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          button,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [edc_pkg::FaceWidth-1:0] left_face,
  output logic [edc_pkg::FaceWidth-1:0] right_face,
  output logic [edc_pkg::LedWidth-1:0]  left_pattern,
  output logic [edc_pkg::LedWidth-1:0]  right_pattern,
  output logic                          shuffling,
  output logic                          asleep
);
  import edc_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEFT,
    S_RIGHT,
    S_DONE
  } ctl_state_t;

  ctl_state_t state;
  logic [SleepWidth-1:0] sleep_ticks;
  logic [FlipWidth-1:0]  flip_ticks;
  logic mode_shuffle;
  logic power_down;
  logic [SleepWidth-1:0] idle_count;
  logic [FlipWidth-1:0]  blink_count;
  logic [FaceWidth-1:0]  left_value;
  logic [FaceWidth-1:0]  right_value;
  logic lit;
  logic draw_start;

  logic draw_done;
  logic [FaceWidth-1:0] draw_face;

  logic [SleepWidth:0] idle_inc;
  logic [FlipWidth:0]  blink_inc;
  logic idle_reached;
  logic blink_reached;
  logic redraw;
  logic display_on;

  edc_draw u_draw (
    .clk   (clk),
    .rst   (rst),
    .start (draw_start),
    .done  (draw_done),
    .face  (draw_face)
  );

  assign in_ready      = (state == S_IDLE);
  assign idle_inc      = {1'b0, idle_count} + 1'b1;
  assign blink_inc     = {1'b0, blink_count} + 1'b1;
  assign idle_reached  = idle_inc >= {1'b0, sleep_ticks};
  assign blink_reached = blink_inc >= {1'b0, flip_ticks};
  assign redraw        = mode_shuffle && button && blink_reached;
  assign display_on    = lit && !power_down;

  always_ff @(posedge clk) begin
    if (rst) begin
      sleep_ticks <= SLEEP_DEFAULT;
      flip_ticks  <= FLIP_DEFAULT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SLEEP_TICKS: sleep_ticks <= cfg_data[SleepWidth-1:0];
        REG_FLIP_TICKS:  flip_ticks  <= cfg_data[FlipWidth-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      mode_shuffle <= 1'b0;
      power_down   <= 1'b0;
      idle_count   <= '0;
      blink_count  <= '0;
      left_value   <= '0;
      right_value  <= '0;
      lit          <= 1'b1;
      draw_start   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          draw_start <= in_valid && redraw;
          if (in_valid) begin
            state <= redraw ? S_LEFT : S_DONE;
            if (!mode_shuffle) begin
              if (power_down) begin
                if (button) begin
                  power_down   <= 1'b0;
                  blink_count  <= '0;
                  mode_shuffle <= 1'b1;
                end
              end else begin
                idle_count <= idle_reached ? '0 : idle_inc[SleepWidth-1:0];
                if (button) begin
                  blink_count  <= '0;
                  mode_shuffle <= 1'b1;
                end else if (idle_reached) begin
                  power_down <= 1'b1;
                end
              end
            end else if (!button) begin
              lit          <= 1'b1;
              idle_count   <= '0;
              mode_shuffle <= 1'b0;
            end else if (blink_reached) begin
              blink_count <= '0;
              lit         <= !lit;
            end else begin
              blink_count <= blink_inc[FlipWidth-1:0];
            end
          end
        end
        S_LEFT: begin
          draw_start <= draw_done;
          if (draw_done) begin
            left_value <= draw_face;
            state      <= S_RIGHT;
          end
        end
        S_RIGHT: begin
          draw_start <= 1'b0;
          if (draw_done) begin
            right_value <= draw_face;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          draw_start <= 1'b0;
          if (!out_valid || out_ready) begin
            left_face     <= left_value;
            right_face    <= right_value;
            left_pattern  <= display_on ? face_leds(left_value) : '0;
            right_pattern <= display_on ? face_leds(right_value) : '0;
            shuffling     <= mode_shuffle;
            asleep        <= power_down;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
